@@ rtl/limit_switch_travel_test_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// limit switch travel test sequencer assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef LIMIT_SWITCH_TRAVEL_TEST_SEQUENCER_DEFINES_SVH
`define LIMIT_SWITCH_TRAVEL_TEST_SEQUENCER_DEFINES_SVH

// checked only while out of reset
`define LSTTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LSTTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lstts_pkg.sv @@
// ----------------------------------------------------------------------------
// lstts_pkg
// types and codes of the limit switch travel test sequencer
// ----------------------------------------------------------------------------
package lstts_pkg;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_DONE  = 2'd2,
        ST_FAULT = 2'd3
    } t_run_state;

    // command codes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // start status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_BUSY    = 2'd2;
    localparam logic [1:0] STAT_FAULT   = 2'd3;

    // register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd10000;
    localparam logic [7:0]  MIN_PASSES     = 8'd1;
    localparam logic [7:0]  MAX_PASSES     = 8'd255;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [31:0] leg_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] time_ms;
        logic        switch_up;
        logic        switch_down;
        logic        motor_fault;
        logic [7:0]  pass_request;
    } t_item;

    typedef struct packed {
        t_run_state  test_state;
        logic [7:0]  target_passes;
        logic [7:0]  completed_passes;
        logic        leg_direction;
        logic        leg_arrived;
        logic        armed_flag;
        logic        held_flag;
        logic [31:0] held_since_ms;
        logic [31:0] leg_begin_ms;
    } t_state;

    localparam t_state STATE_RESET = '{
        test_state:       ST_IDLE,
        target_passes:    8'd0,
        completed_passes: 8'd0,
        leg_direction:    1'b0,
        leg_arrived:      1'b0,
        armed_flag:       1'b1,
        held_flag:        1'b0,
        held_since_ms:    32'd0,
        leg_begin_ms:     32'd0
    };

    typedef struct packed {
        t_run_state  run_state;
        logic        motor_on;
        logic        direction;
        logic        leg_started;
        logic [7:0]  passes_total;
        logic [7:0]  passes_done;
        logic [1:0]  start_status;
    } t_result;

endpackage

@@ rtl/limit_switch_travel_test_sequencer.sv @@
// ----------------------------------------------------------------------------
// limit_switch_travel_test_sequencer
// back-and-forth motor endurance test between two limit switches
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                       payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata 48b, tuser = mode
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata 24b result
// cfg       in         i_cfg_valid/o_cfg_ready          index 1b, data 32b
//
// one beat per cycle sustained while the output is not stalled; a beat's result
//   passes through the input register, then the step logic into the result
//   register, before it shows on the output
// the state is updated in the cycle a beat moves into the result register
// reset is synchronous and clears the state and both valid flags; the payload registers are not reset
// a stalled output holds one result while one more beat waits in the input
//   register; after that the input side stalls too
//
module limit_switch_travel_test_sequencer
    import lstts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command / tick stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] time_ms, [32] switch_up, [33] switch_down, [34] motor_fault,
    // [42:35] pass_request, [47:43] zero
    input  logic [47:0] i_s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] run_state, [2] motor_on, [3] direction, [4] leg_started,
    // [12:5] passes_total, [20:13] passes_done, [22:21] start_status, [23] zero
    output logic [23:0] o_m_axis_tdata,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    `include "limit_switch_travel_test_sequencer_defines.svh"

    t_cfg    w_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_state  r_state;
    t_state  w_next_state;
    t_result w_result;
    logic    w_advance;
    logic    w_s_accept;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    lstts_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // the held beat moves on when the result register is free or emptying
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= w_next_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in.mode         <= i_s_axis_tuser;
            r_in.time_ms      <= i_s_axis_tdata[31:0];
            r_in.switch_up    <= i_s_axis_tdata[32];
            r_in.switch_down  <= i_s_axis_tdata[33];
            r_in.motor_fault  <= i_s_axis_tdata[34];
            r_in.pass_request <= i_s_axis_tdata[42:35];
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    lstts_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .o_state  (w_next_state),
        .o_result (w_result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.start_status, r_out.passes_done,
                              r_out.passes_total, r_out.leg_started, r_out.direction,
                              r_out.motor_on, r_out.run_state};

    // state only moves with a beat
    `LSTTS_ASSERT(a_state_holds, i_clk, i_rst_n, !w_advance |=> ($stable(r_state) || !$past(i_rst_n)), "state changed without a beat")
    // motor runs exactly while running
    `LSTTS_ASSERT(a_motor_on, i_clk, i_rst_n, r_out_valid |-> (r_out.motor_on == (r_out.run_state == ST_RUN)), "motor_on disagrees with run state")
    // a new leg only while running and with no rejected start
    `LSTTS_ASSERT(a_leg_pulse, i_clk, i_rst_n, (r_out_valid && r_out.leg_started) |-> ((r_out.run_state == ST_RUN) && (r_out.start_status == STAT_OK)), "leg pulse outside a running test")
    // reset drops both valid flags
    `LSTTS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid), "pipeline not empty after reset")

endmodule

@@ rtl/lstts_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lstts_cfg_regs
// debounce and leg timeout registers behind the write channel
// ----------------------------------------------------------------------------
module lstts_cfg_regs
    import lstts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic        i_wr_index,
    input  logic [31:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= DEBOUNCE_RESET;
            r_cfg.leg_timeout_ms <= TIMEOUT_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_DEBOUNCE: r_cfg.debounce_ms    <= i_wr_data[15:0];
                CFG_TIMEOUT:  r_cfg.leg_timeout_ms <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/lstts_step.sv @@
// ----------------------------------------------------------------------------
// lstts_step
// next state and result for one command or tick
// ----------------------------------------------------------------------------
module lstts_step
    import lstts_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [31:0] w_since;
    logic [31:0] w_held_age;
    logic [31:0] w_leg_age;
    logic        w_debounced;
    logic        w_timed_out;
    logic [7:0]  w_count_inc;

    // a fresh hold starts counting at this tick
    assign w_since     = i_state.held_flag ? i_state.held_since_ms : i_item.time_ms;
    assign w_held_age  = i_item.time_ms - w_since;
    assign w_leg_age   = i_item.time_ms - i_state.leg_begin_ms;
    assign w_debounced = w_held_age >= {16'd0, i_cfg.debounce_ms};
    assign w_timed_out = w_leg_age >= i_cfg.leg_timeout_ms;
    assign w_count_inc = (i_state.completed_passes < MAX_PASSES)
                       ? i_state.completed_passes + 8'd1 : i_state.completed_passes;

    always_comb begin
        logic arrive;
        logic started;
        logic [1:0] status;
        t_state nxt;
        nxt     = i_state;
        arrive  = 1'b0;
        started = 1'b0;
        status  = STAT_OK;
        case (i_item.mode)
            MODE_TICK: begin
                if (i_state.test_state == ST_RUN) begin
                    if (i_item.motor_fault) begin
                        nxt.test_state = ST_FAULT;
                    end else begin
                        if (i_item.switch_up || i_item.switch_down) begin
                            nxt.held_flag     = 1'b1;
                            nxt.held_since_ms = w_since;
                            if (i_state.armed_flag && !i_state.leg_arrived && w_debounced) begin
                                arrive         = 1'b1;
                                nxt.leg_arrived = 1'b1;
                                nxt.armed_flag = 1'b0;
                                if (i_state.leg_direction) begin
                                    nxt.completed_passes = w_count_inc;
                                end
                                if (i_state.leg_direction
                                    && (w_count_inc >= i_state.target_passes)) begin
                                    nxt.test_state = ST_DONE;
                                end else begin
                                    nxt.leg_direction = ~i_state.leg_direction;
                                    nxt.leg_arrived   = 1'b0;
                                    nxt.leg_begin_ms  = i_item.time_ms;
                                    started           = 1'b1;
                                end
                            end
                        end else begin
                            nxt.held_flag  = 1'b0;
                            nxt.armed_flag = 1'b1;
                        end
                        if (!arrive && w_timed_out) begin
                            nxt.test_state = ST_FAULT;
                        end
                    end
                end
            end
            MODE_START: begin
                if (i_item.pass_request < MIN_PASSES) begin
                    status = STAT_INVALID;
                end else if (i_state.test_state == ST_RUN) begin
                    status = STAT_BUSY;
                end else if (i_item.motor_fault) begin
                    status = STAT_FAULT;
                end else begin
                    nxt.target_passes    = i_item.pass_request;
                    nxt.completed_passes = 8'd0;
                    nxt.armed_flag       = 1'b1;
                    nxt.held_flag        = 1'b0;
                    nxt.test_state       = ST_RUN;
                    nxt.leg_direction    = 1'b0;
                    nxt.leg_arrived      = 1'b0;
                    nxt.leg_begin_ms     = i_item.time_ms;
                    started              = 1'b1;
                end
            end
            MODE_STOP: begin
                nxt.target_passes    = 8'd0;
                nxt.completed_passes = 8'd0;
                nxt.test_state       = ST_IDLE;
            end
            default: ;
        endcase

        o_state                  = nxt;
        o_result.run_state       = nxt.test_state;
        o_result.motor_on        = (nxt.test_state == ST_RUN);
        o_result.direction       = nxt.leg_direction;
        o_result.leg_started     = started;
        o_result.passes_total    = nxt.target_passes;
        o_result.passes_done     = nxt.completed_passes;
        o_result.start_status    = status;
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// limit switch travel test sequencer testbench
// streams directed and random command/tick beats into the sequencer, mirrors
// its test state in a local predictor and checks every result beat field by
// field; switches debounce and timeout settings between drained phases
// ----------------------------------------------------------------------------
module testbench
    import lstts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // the fourth mode value is unused and must leave the state alone
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [31:0] time_ms, [32] switch_up, [33] switch_down, [34] motor_fault,
    // [42:35] pass_request, [47:43] zero
    logic [47:0] i_s_axis_tdata = '0;
    // [1:0] mode
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [1:0] run_state, [2] motor_on, [3] direction, [4] leg_started,
    // [12:5] passes_total, [20:13] passes_done, [22:21] start_status, [23] zero
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    limit_switch_travel_test_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // shadow copy of the sequencer state and its settings
    // ------------------------------------------------------------------
    t_run_state  run_st       = ST_IDLE;
    logic [7:0]  trips_goal   = 8'd0;
    logic [7:0]  trips_done   = 8'd0;
    logic        leg_dir      = 1'b0;
    logic        leg_done     = 1'b0;
    logic        sw_armed     = 1'b1;
    logic        sw_held      = 1'b0;
    logic [31:0] held_at      = 32'd0;
    logic [31:0] leg_t0       = 32'd0;
    logic [15:0] dbnc_ms      = DEBOUNCE_RESET;
    logic [31:0] leg_limit_ms = TIMEOUT_RESET;

    t_item   pending_cmds[$];     // beats waiting for the driver
    t_result expected_status[$];  // predicted result beats, oldest first
    t_item   beat_on_bus;         // beat currently offered to the block
    int      items_queued = 0;
    int      fail_count = 0;
    logic    steady_run = 1'b0;   // no idling on either side while set
    logic    choke_req = 1'b0;    // asks the receiver for a long hold-off
    int      choke_left = 0;
    logic [31:0] sim_ms = 32'd100;  // millisecond clock seen by the block

    // advance the shadow state by one accepted beat and return its result
    function automatic t_result predict_test_status(input t_item b);
        t_result    r;
        logic       started;
        logic [1:0] status;
        logic       timed;
        started = 1'b0;
        status  = STAT_OK;
        timed   = 1'b0;
        case (b.mode)
            MODE_TICK: begin
                if (run_st == ST_RUN) begin
                    if (b.motor_fault) begin
                        run_st = ST_FAULT;
                    end else begin
                        timed = 1'b1;
                        if (b.switch_up || b.switch_down) begin
                            if (!sw_held) begin
                                sw_held = 1'b1;
                                held_at = b.time_ms;
                            end
                            // arrival: switch held long enough on an armed leg
                            if (sw_armed && !leg_done &&
                                (b.time_ms - held_at) >= {16'd0, dbnc_ms}) begin
                                leg_done = 1'b1;
                                sw_armed = 1'b0;
                                timed    = 1'b0;
                                if (leg_dir) begin
                                    if (trips_done != MAX_PASSES)
                                        trips_done = trips_done + 8'd1;
                                    if (trips_done >= trips_goal)
                                        run_st = ST_DONE;
                                end
                                if (run_st == ST_RUN) begin
                                    leg_dir  = ~leg_dir;
                                    leg_done = 1'b0;
                                    leg_t0   = b.time_ms;
                                    started  = 1'b1;
                                end
                            end
                        end else begin
                            // both released: re-arm for the next arrival
                            sw_held  = 1'b0;
                            sw_armed = 1'b1;
                        end
                        if (timed && (b.time_ms - leg_t0) >= leg_limit_ms)
                            run_st = ST_FAULT;
                    end
                end
            end
            MODE_START: begin
                if (b.pass_request < MIN_PASSES) begin
                    status = STAT_INVALID;
                end else if (run_st == ST_RUN) begin
                    status = STAT_BUSY;
                end else if (b.motor_fault) begin
                    status = STAT_FAULT;
                end else begin
                    trips_goal = b.pass_request;
                    trips_done = 8'd0;
                    sw_armed   = 1'b1;
                    sw_held    = 1'b0;
                    run_st     = ST_RUN;
                    leg_dir    = 1'b0;
                    leg_done   = 1'b0;
                    leg_t0     = b.time_ms;
                    started    = 1'b1;
                end
            end
            MODE_STOP: begin
                trips_goal = 8'd0;
                trips_done = 8'd0;
                run_st     = ST_IDLE;
            end
            default: ;
        endcase
        r.run_state    = run_st;
        r.motor_on     = (run_st == ST_RUN);
        r.direction    = leg_dir;
        r.leg_started  = started;
        r.passes_total = trips_goal;
        r.passes_done  = trips_done;
        r.start_status = status;
        return r;
    endfunction

    function automatic logic field_bad(input string nm, input logic [7:0] want,
                                       input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // command driver: predicts each beat as it is taken, then offers the
    // next one unless it decides to idle this cycle
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_cmds
        t_item nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_status.push_back(predict_test_status(beat_on_bus));
            // slot is free when nothing is offered or the offer was just taken
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_cmds.size() != 0 && (steady_run || $urandom_range(99) >= 11)) begin
                    nxt = pending_cmds.pop_front();
                    beat_on_bus     <= nxt;
                    i_s_axis_tdata  <= {5'd0, nxt.pass_request, nxt.motor_fault,
                                        nxt.switch_down, nxt.switch_up, nxt.time_ms};
                    i_s_axis_tuser  <= nxt.mode;
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drain_results
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (choke_left != 0) begin
            choke_left = choke_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (choke_req) begin
            choke_req  = 1'b0;
            choke_left = 80;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= steady_run || ($urandom_range(99) >= 11);
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result want;
        logic    bad;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_status.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, o_m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_status.pop_front();
                bad = 1'b0;
                bad |= field_bad("run_state", 8'(want.run_state), 8'(o_m_axis_tdata[1:0]));
                bad |= field_bad("motor_on", 8'(want.motor_on), 8'(o_m_axis_tdata[2]));
                bad |= field_bad("direction", 8'(want.direction), 8'(o_m_axis_tdata[3]));
                bad |= field_bad("leg_started", 8'(want.leg_started), 8'(o_m_axis_tdata[4]));
                bad |= field_bad("passes_total", want.passes_total, o_m_axis_tdata[12:5]);
                bad |= field_bad("passes_done", want.passes_done, o_m_axis_tdata[20:13]);
                bad |= field_bad("start_status", 8'(want.start_status),
                                 8'(o_m_axis_tdata[22:21]));
                if (bad)
                    fail_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic [1:0] md, input logic [31:0] t, input logic up,
                              input logic dn, input logic flt, input logic [7:0] req);
        t_item b;
        b.mode         = md;
        b.time_ms      = t;
        b.switch_up    = up;
        b.switch_down  = dn;
        b.motor_fault  = flt;
        b.pass_request = req;
        pending_cmds.push_back(b);
        items_queued++;
    endtask

    task automatic queue_random_beat;
        queue_beat(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // a tick at the current time, now and then replaced by a disturbance
    task automatic queue_tick(input logic up, input logic dn);
        int r;
        r = $urandom_range(999);
        if (r < 3)
            queue_beat(MODE_TICK, sim_ms, up, dn, 1'b1, 8'($urandom_range(255)));
        else if (r < 4)
            queue_beat(MODE_STOP, sim_ms, up, dn, 1'($urandom_range(1)),
                       8'($urandom_range(255)));
        else if (r < 7)
            queue_beat(MODE_START, sim_ms, up, dn, 1'($urandom_range(1)),
                       8'($urandom_range(255)));
        else if (r < 10)
            queue_beat(MODE_SPARE, sim_ms, up, dn, 1'($urandom_range(1)),
                       8'($urandom_range(255)));
        else if (r < 12)
            queue_random_beat();
        else
            queue_beat(MODE_TICK, sim_ms, up, dn, 1'b0, 8'($urandom_range(255)));
    endtask

    // one well-formed endurance run: start, then travel and arrive for each leg
    task automatic queue_test_run(input int passes);
        logic [31:0] held_t0;
        logic        up;
        logic        dn;
        int          travel_max;
        travel_max = (leg_limit_ms > 32'd4000) ? 500 : int'(leg_limit_ms / 8) + 1;
        queue_beat(MODE_START, sim_ms, 1'b0, 1'b0, $urandom_range(99) < 4, 8'(passes));
        for (int leg = 0; leg < 2 * passes; leg++) begin
            // travel with both switches released
            repeat ($urandom_range(1, 4)) begin
                sim_ms = sim_ms + $urandom_range(1, travel_max);
                queue_tick(1'b0, 1'b0);
            end
            // forward legs end on the upper switch, reverse legs on the lower
            up = (leg % 2 == 0);
            dn = ~up;
            if ($urandom_range(9) == 0) begin
                up = 1'b1;
                dn = 1'b1;
            end
            held_t0 = sim_ms;
            forever begin
                queue_tick(up, dn);
                if ((sim_ms - held_t0) >= {16'd0, dbnc_ms})
                    break;
                sim_ms = sim_ms + $urandom_range(1, int'(dbnc_ms) / 2 + 1);
                // contact bounce restarts the debounce window
                if ($urandom_range(19) == 0) begin
                    queue_tick(1'b0, 1'b0);
                    sim_ms  = sim_ms + 1;
                    held_t0 = sim_ms;
                end
            end
            // switch still held after arrival must not end the new leg
            repeat ($urandom_range(0, 2)) begin
                sim_ms = sim_ms + $urandom_range(1, 20);
                queue_tick(up, dn);
            end
        end
    endtask

    task automatic wait_drained;
        while (pending_cmds.size() != 0 || i_s_axis_tvalid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            dbnc_ms = val[15:0];
        else
            leg_limit_ms = val;
    endtask

    // drain, apply new settings, then queue runs and random beats until the budget is spent
    task automatic run_phase(input logic [15:0] dbnc, input logic [31:0] limit,
                             input int budget);
        logic [15:0] junk;
        int          first;
        junk = 16'($urandom_range(65535));
        wait_drained();
        // upper bits of the debounce write are not part of the register
        write_reg(CFG_DEBOUNCE, {junk, dbnc});
        write_reg(CFG_TIMEOUT, limit);
        if ($urandom_range(3) == 0)
            sim_ms = 32'hFFFF_FF00 + $urandom_range(255);
        first = items_queued;
        while (items_queued - first < budget) begin
            if ($urandom_range(9) == 0)
                repeat (5) queue_random_beat();
            else if ($urandom_range(9) == 0)
                queue_test_run($urandom_range(4, 8));
            else
                queue_test_run($urandom_range(1, 3));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings (debounce 20, timeout 10000)
        queue_beat(MODE_SPARE, 32'h5A5A_A5A5, 1'b1, 1'b0, 1'b1, 8'hAA);
        queue_beat(MODE_TICK, 32'd100, 1'b1, 1'b1, 1'b1, 8'd0);         // idle tick
        queue_beat(MODE_START, 32'd110, 1'b0, 1'b0, 1'b0, 8'd0);        // zero count
        queue_beat(MODE_START, 32'd120, 1'b0, 1'b0, 1'b1, 8'd1);        // driver fault
        queue_beat(MODE_START, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 8'd255);
        queue_beat(MODE_START, 32'hFFFF_FFF1, 1'b0, 1'b0, 1'b0, 8'd3);  // busy
        queue_beat(MODE_START, 32'hFFFF_FFF2, 1'b0, 1'b0, 1'b1, 8'd0);  // invalid wins
        queue_beat(MODE_TICK, 32'd5, 1'b0, 1'b0, 1'b1, 8'd0);           // fault while running
        queue_beat(MODE_START, 32'd1000, 1'b0, 1'b0, 1'b0, 8'd1);       // restart from fault
        queue_beat(MODE_TICK, 32'd1010, 1'b0, 1'b0, 1'b0, 8'd0);
        queue_beat(MODE_TICK, 32'd1020, 1'b1, 1'b0, 1'b0, 8'd0);
        queue_beat(MODE_TICK, 32'd1039, 1'b1, 1'b0, 1'b0, 8'd0);        // one short
        queue_beat(MODE_TICK, 32'd1040, 1'b1, 1'b0, 1'b0, 8'd0);        // arrival
        queue_beat(MODE_TICK, 32'd1050, 1'b1, 1'b0, 1'b0, 8'd0);        // still held
        queue_beat(MODE_TICK, 32'd1060, 1'b0, 1'b0, 1'b0, 8'd0);        // re-arm
        queue_beat(MODE_TICK, 32'd1070, 1'b0, 1'b1, 1'b0, 8'd0);
        queue_beat(MODE_TICK, 32'd1090, 1'b0, 1'b1, 1'b0, 8'd0);        // last pass
        queue_beat(MODE_TICK, 32'd1100, 1'b1, 1'b1, 1'b1, 8'd0);        // tick in done
        queue_beat(MODE_STOP, 32'd1110, 1'b0, 1'b0, 1'b0, 8'd0);        // keeps direction
        queue_beat(MODE_START, 32'd2000, 1'b0, 1'b0, 1'b0, 8'd2);
        queue_beat(MODE_TICK, 32'd12000, 1'b0, 1'b0, 1'b0, 8'd0);       // leg timeout
        queue_beat(MODE_START, 32'd12010, 1'b0, 1'b0, 1'b0, 8'd128);    // start from fault
        queue_beat(MODE_STOP, 32'd12020, 1'b1, 1'b1, 1'b1, 8'd255);
        queue_beat(MODE_STOP, 32'd12030, 1'b0, 1'b0, 1'b0, 8'd0);       // stop from idle
        queue_beat(MODE_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'hFF);

        // zero debounce, then the widest settings with a long receiver hold-off
        run_phase(16'd0, 32'd10000, 150);
        run_phase(16'hFFFF, 32'hFFFF_FFFF, 150);
        choke_req = 1'b1;
        // zero timeout faults every running tick without an arrival
        run_phase(16'd20, 32'd0, 60);
        run_phase(16'd5, 32'd300, 120);

        // a stretch with no idling at all
        wait_drained();
        steady_run = 1'b1;
        run_phase(DEBOUNCE_RESET, TIMEOUT_RESET, 200);
        wait_drained();
        steady_run = 1'b0;

        while (items_queued < 1550) begin
            if ($urandom_range(4) == 0)
                run_phase(16'($urandom_range(65535)), $urandom, 150);
            else
                run_phase(16'($urandom_range(200)), $urandom_range(500, 20000), 150);
            if ($urandom_range(2) == 0)
                choke_req = 1'b1;
        end

        wait_drained();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
